@@ rtl/tfd_pkg.sv @@
`timescale 1ns / 1ps

package tfd_pkg;

  localparam int unsigned WordBytes = 4;

  localparam logic [31:0] MagicReset = 32'd1995;
  localparam logic [7:0]  LimitReset = 8'd9;

  localparam logic [1:0] REG_MAGIC = 2'd0;
  localparam logic [1:0] REG_LIMIT = 2'd1;

  localparam logic [3:0] PH_MAGIC   = 4'd0;
  localparam logic [3:0] PH_ATOMS   = 4'd1;
  localparam logic [3:0] PH_STEP    = 4'd2;
  localparam logic [3:0] PH_TIME    = 4'd3;
  localparam logic [3:0] PH_BOX     = 4'd4;
  localparam logic [3:0] PH_COUNT   = 4'd5;
  localparam logic [3:0] PH_PREC    = 4'd6;
  localparam logic [3:0] PH_MIN     = 4'd7;
  localparam logic [3:0] PH_MAX     = 4'd8;
  localparam logic [3:0] PH_SMALL   = 4'd9;
  localparam logic [3:0] PH_LEN     = 4'd10;
  localparam logic [3:0] PH_PAYLOAD = 4'd11;
  localparam logic [3:0] PH_PAD     = 4'd12;

  localparam logic [3:0] K_ATOMS    = 4'd0;
  localparam logic [3:0] K_STEP     = 4'd1;
  localparam logic [3:0] K_TIME     = 4'd2;
  localparam logic [3:0] K_BOX      = 4'd3;
  localparam logic [3:0] K_COUNT    = 4'd4;
  localparam logic [3:0] K_PREC     = 4'd5;
  localparam logic [3:0] K_MIN      = 4'd6;
  localparam logic [3:0] K_MAX      = 4'd7;
  localparam logic [3:0] K_SMALL    = 4'd8;
  localparam logic [3:0] K_LENGTH   = 4'd9;
  localparam logic [3:0] K_PAYLOAD  = 4'd10;
  localparam logic [3:0] K_END      = 4'd11;
  localparam logic [3:0] K_ERROR    = 4'd12;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_MAGIC  = 2'd1;
  localparam logic [1:0] ERR_COUNT  = 2'd2;
  localparam logic [1:0] ERR_ATOMS  = 2'd3;

  localparam logic [3:0] BoxLast   = 4'd8;
  localparam logic [3:0] TripleLast = 4'd2;

  typedef struct packed {
    logic [31:0] frame_magic;
    logic [7:0]  small_count_limit;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    logic [3:0]  kind;
    logic [31:0] value;
    logic [3:0]  idx;
    logic [1:0]  err;
    logic        last;
  } result_t;

endpackage

@@ rtl/trajectory_frame_deframer.sv @@
`timescale 1ns / 1ps
// Channel   Handshake                 Payload
// byte      byte_valid / byte_ready   data_byte
// record    rec_valid / rec_ready     record_kind, word_value, element_index,
//                                     error_code, last
// cfg       cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One byte per cycle sustained while records are taken: input register, one parse stage, output register.
// A taken byte is held in the input register; its record is then registered in the output register.
// Synchronous reset; cfg_ready is always high.
// A stalled record holds the parse stage; the input register still takes one byte if it is empty.
// After an error, bytes are taken and dropped until reset.

module trajectory_frame_deframer import tfd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_ready,
  input  logic [7:0]         data_byte,
  output logic               rec_valid,
  input  logic               rec_ready,
  output logic [3:0]         record_kind,
  output logic signed [31:0] word_value,
  output logic [3:0]         element_index,
  output logic [1:0]         error_code,
  output logic               last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  cfg_t       cfg;
  result_t    res;
  logic       held_valid;
  logic [7:0] held_byte;
  logic       advance;

  assign advance    = held_valid && (!rec_valid || rec_ready);
  assign byte_ready = !held_valid || advance;

  tfd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tfd_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .data_byte (held_byte),
    .cfg       (cfg),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (byte_ready) begin
      held_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && byte_ready) begin
      held_byte <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else if (advance) begin
      rec_valid <= res.valid;
    end else if (rec_ready) begin
      rec_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      record_kind   <= res.kind;
      word_value    <= res.value;
      element_index <= res.idx;
      error_code    <= res.err;
      last          <= res.last;
    end
  end

`ifndef NO_ASSERTIONS
  a_err_matches_kind: assert property (@(posedge clk) disable iff (rst)
    rec_valid |-> ((error_code != ERR_NONE) == (record_kind == K_ERROR)))
    else $error("error code and record kind disagree");

  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    rec_valid && last |->
      (record_kind == K_PAYLOAD || record_kind == K_LENGTH || record_kind == K_END))
    else $error("frame end flagged on a header record");

  a_index_kind: assert property (@(posedge clk) disable iff (rst)
    rec_valid && element_index != 4'd0 |->
      (record_kind == K_BOX || record_kind == K_MIN || record_kind == K_MAX))
    else $error("element index outside a group");
`endif

endmodule

@@ rtl/tfd_cfg.sv @@
`timescale 1ns / 1ps

module tfd_cfg import tfd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output cfg_t        cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_magic       <= MagicReset;
      cfg.small_count_limit <= LimitReset;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MAGIC: cfg.frame_magic       <= cfg_data;
        REG_LIMIT: cfg.small_count_limit <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/tfd_parse.sv @@
`timescale 1ns / 1ps

module tfd_parse import tfd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] data_byte,
  input  cfg_t       cfg,
  output result_t    res
);

  logic [3:0]  parse_phase, parse_phase_next;
  logic [1:0]  byte_in_word, byte_in_word_next;
  logic [23:0] partial_word, partial_word_next;
  logic [3:0]  group_index, group_index_next;
  logic [31:0] atom_total, atom_total_next;
  logic [31:0] payload_left, payload_left_next;
  logic [1:0]  pad_left, pad_left_next;
  logic        halted, halted_next;

  logic [31:0] word;
  logic [31:0] left_dec;
  logic [1:0]  pad_dec;
  logic [1:0]  len_pad;

  assign word     = {partial_word, data_byte};
  assign left_dec = payload_left - 32'd1;
  assign pad_dec  = pad_left - 2'd1;
  assign len_pad  = ~word[1:0] + 2'd1;

  always_comb begin
    parse_phase_next  = parse_phase;
    byte_in_word_next = byte_in_word;
    partial_word_next = partial_word;
    group_index_next  = group_index;
    atom_total_next   = atom_total;
    payload_left_next = payload_left;
    pad_left_next     = pad_left;
    halted_next       = halted;
    res               = '0;
    res.value         = word;

    if (halted) begin
      res.valid = 1'b0;
    end else if (parse_phase == PH_PAYLOAD) begin
      payload_left_next = left_dec;
      res.valid = 1'b1;
      res.kind  = K_PAYLOAD;
      res.value = {24'd0, data_byte};
      if (left_dec == 32'd0) begin
        if (pad_left == 2'd0) begin
          parse_phase_next = PH_MAGIC;
          res.last = 1'b1;
        end else begin
          parse_phase_next = PH_PAD;
        end
      end
    end else if (parse_phase == PH_PAD) begin
      pad_left_next = pad_dec;
      if (pad_dec == 2'd0) begin
        parse_phase_next = PH_MAGIC;
        res.valid = 1'b1;
        res.kind  = K_END;
        res.value = '0;
        res.last  = 1'b1;
      end
    end else if (byte_in_word != 2'(WordBytes - 1)) begin
      partial_word_next = {partial_word[15:0], data_byte};
      byte_in_word_next = byte_in_word + 2'd1;
    end else begin
      partial_word_next = '0;
      byte_in_word_next = '0;
      res.valid = 1'b1;
      case (parse_phase)
        PH_ATOMS: begin
          atom_total_next  = word;
          parse_phase_next = PH_STEP;
          res.kind = K_ATOMS;
        end
        PH_STEP: begin
          parse_phase_next = PH_TIME;
          res.kind = K_STEP;
        end
        PH_TIME: begin
          parse_phase_next = PH_BOX;
          group_index_next = '0;
          res.kind = K_TIME;
        end
        PH_BOX: begin
          res.kind = K_BOX;
          res.idx  = group_index;
          group_index_next = group_index + 4'd1;
          if (group_index >= BoxLast) begin
            group_index_next = '0;
            parse_phase_next = PH_COUNT;
          end
        end
        PH_COUNT: begin
          if ($signed(atom_total) < $signed(word)) begin
            halted_next = 1'b1;
            res.kind = K_ERROR;
            res.err  = ERR_COUNT;
          end else if ($signed(atom_total) <= $signed({24'd0, cfg.small_count_limit})) begin
            halted_next = 1'b1;
            res.kind = K_ERROR;
            res.err  = ERR_ATOMS;
          end else begin
            parse_phase_next = PH_PREC;
            res.kind = K_COUNT;
          end
        end
        PH_PREC: begin
          parse_phase_next = PH_MIN;
          group_index_next = '0;
          res.kind = K_PREC;
        end
        PH_MIN, PH_MAX: begin
          res.kind = (parse_phase == PH_MIN) ? K_MIN : K_MAX;
          res.idx  = group_index;
          group_index_next = group_index + 4'd1;
          if (group_index >= TripleLast) begin
            group_index_next = '0;
            parse_phase_next = (parse_phase == PH_MIN) ? PH_MAX : PH_SMALL;
          end
        end
        PH_SMALL: begin
          parse_phase_next = PH_LEN;
          res.kind = K_SMALL;
        end
        PH_LEN: begin
          payload_left_next = word;
          pad_left_next     = len_pad;
          res.kind = K_LENGTH;
          if (word != 32'd0) begin
            parse_phase_next = PH_PAYLOAD;
          end else begin
            parse_phase_next = PH_MAGIC;
            res.last = 1'b1;
          end
        end
        default: begin
          if (word != cfg.frame_magic) begin
            halted_next = 1'b1;
            res.kind = K_ERROR;
            res.err  = ERR_MAGIC;
          end else begin
            parse_phase_next = PH_ATOMS;
            res.valid = 1'b0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase  <= PH_MAGIC;
      byte_in_word <= '0;
      partial_word <= '0;
      group_index  <= '0;
      atom_total   <= '0;
      payload_left <= '0;
      pad_left     <= '0;
      halted       <= 1'b0;
    end else if (step) begin
      parse_phase  <= parse_phase_next;
      byte_in_word <= byte_in_word_next;
      partial_word <= partial_word_next;
      group_index  <= group_index_next;
      atom_total   <= atom_total_next;
      payload_left <= payload_left_next;
      pad_left     <= pad_left_next;
      halted       <= halted_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_halt_sticks: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("halt released without reset");

  a_payload_nonzero: assert property (@(posedge clk) disable iff (rst)
    parse_phase == PH_PAYLOAD |-> payload_left != 32'd0)
    else $error("payload phase with nothing left");

  a_pad_nonzero: assert property (@(posedge clk) disable iff (rst)
    parse_phase == PH_PAD |-> pad_left != 2'd0)
    else $error("pad phase with empty pad");
`endif

endmodule

@@ test/trajectory_frame_deframer_tb.sv @@
`timescale 1ns / 1ps

module trajectory_frame_deframer_tb;
  import tfd_pkg::*;

  localparam logic [1:0] REG_SPARE = 2'd2;
  localparam logic [1:0] REG_TOP   = 2'd3;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES   = 80;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned PHASE_BYTES   = 90;

  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;
  typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PATTERN} rx_mode_t;

  class record_scoreboard;
    logic [31:0] magic_word;
    logic [7:0]  atom_floor;
    logic [3:0]  phase;
    logic [1:0]  byte_pos;
    logic [23:0] word_acc;
    logic [3:0]  slot;
    logic [31:0] atoms;
    logic [31:0] bytes_left;
    logic [1:0]  pad_left;
    bit          stopped;
    result_t     due_records[$];
    int unsigned mismatches;
    int unsigned checked;

    function new();
      magic_word = MagicReset;
      atom_floor = LimitReset;
      phase      = PH_MAGIC;
      byte_pos   = 2'd0;
      word_acc   = 24'd0;
      slot       = 4'd0;
      atoms      = 32'd0;
      bytes_left = 32'd0;
      pad_left   = 2'd0;
      stopped    = 1'b0;
      mismatches = 0;
      checked    = 0;
    endfunction

    function int unsigned pending();
      return due_records.size();
    endfunction

    function void set_reg(logic [1:0] index, logic [31:0] data);
      if (index == REG_MAGIC) begin
        magic_word = data;
      end else if (index == REG_LIMIT) begin
        atom_floor = data[7:0];
      end
    endfunction

    function void queue_record(logic [3:0] kind, logic [31:0] value, logic [3:0] idx,
                               logic [1:0] err, logic last_flag);
      result_t r;
      r.valid = 1'b1;
      r.kind  = kind;
      r.value = value;
      r.idx   = idx;
      r.err   = err;
      r.last  = last_flag;
      due_records.push_back(r);
    endfunction

    function void halt(logic [31:0] word, logic [1:0] code);
      stopped = 1'b1;
      queue_record(K_ERROR, word, 4'd0, code, 1'b0);
    endfunction

    // advance the frame parser by one byte
    function void take_byte(logic [7:0] b);
      logic [31:0] word;
      if (stopped) return;
      if (phase == PH_PAYLOAD) begin
        bytes_left = bytes_left - 32'd1;
        if (bytes_left != 32'd0) begin
          queue_record(K_PAYLOAD, {24'd0, b}, 4'd0, ERR_NONE, 1'b0);
        end else if (pad_left == 2'd0) begin
          phase = PH_MAGIC;
          queue_record(K_PAYLOAD, {24'd0, b}, 4'd0, ERR_NONE, 1'b1);
        end else begin
          phase = PH_PAD;
          queue_record(K_PAYLOAD, {24'd0, b}, 4'd0, ERR_NONE, 1'b0);
        end
        return;
      end
      if (phase == PH_PAD) begin
        pad_left = pad_left - 2'd1;
        if (pad_left == 2'd0) begin
          phase = PH_MAGIC;
          queue_record(K_END, 32'd0, 4'd0, ERR_NONE, 1'b1);
        end
        return;
      end
      if (byte_pos != 2'd3) begin
        word_acc = {word_acc[15:0], b};
        byte_pos = byte_pos + 2'd1;
        return;
      end
      word = {word_acc, b};
      word_acc = 24'd0;
      byte_pos = 2'd0;
      case (phase)
        PH_ATOMS: begin
          atoms = word;
          phase = PH_STEP;
          queue_record(K_ATOMS, word, 4'd0, ERR_NONE, 1'b0);
        end
        PH_STEP: begin
          phase = PH_TIME;
          queue_record(K_STEP, word, 4'd0, ERR_NONE, 1'b0);
        end
        PH_TIME: begin
          phase = PH_BOX;
          slot = 4'd0;
          queue_record(K_TIME, word, 4'd0, ERR_NONE, 1'b0);
        end
        PH_BOX: begin
          queue_record(K_BOX, word, slot, ERR_NONE, 1'b0);
          if (slot == BoxLast) begin
            slot = 4'd0;
            phase = PH_COUNT;
          end else begin
            slot = slot + 4'd1;
          end
        end
        PH_COUNT: begin
          if ($signed(word) > $signed(atoms)) begin
            halt(word, ERR_COUNT);
          end else if ($signed(atoms) <= $signed({24'd0, atom_floor})) begin
            halt(word, ERR_ATOMS);
          end else begin
            phase = PH_PREC;
            queue_record(K_COUNT, word, 4'd0, ERR_NONE, 1'b0);
          end
        end
        PH_PREC: begin
          phase = PH_MIN;
          slot = 4'd0;
          queue_record(K_PREC, word, 4'd0, ERR_NONE, 1'b0);
        end
        PH_MIN: begin
          queue_record(K_MIN, word, slot, ERR_NONE, 1'b0);
          if (slot == TripleLast) begin
            slot = 4'd0;
            phase = PH_MAX;
          end else begin
            slot = slot + 4'd1;
          end
        end
        PH_MAX: begin
          queue_record(K_MAX, word, slot, ERR_NONE, 1'b0);
          if (slot == TripleLast) begin
            slot = 4'd0;
            phase = PH_SMALL;
          end else begin
            slot = slot + 4'd1;
          end
        end
        PH_SMALL: begin
          phase = PH_LEN;
          queue_record(K_SMALL, word, 4'd0, ERR_NONE, 1'b0);
        end
        PH_LEN: begin
          bytes_left = word;
          pad_left = 2'd0 - word[1:0];
          if (word != 32'd0) begin
            phase = PH_PAYLOAD;
            queue_record(K_LENGTH, word, 4'd0, ERR_NONE, 1'b0);
          end else if (pad_left != 2'd0) begin
            phase = PH_PAD;
            queue_record(K_LENGTH, word, 4'd0, ERR_NONE, 1'b0);
          end else begin
            phase = PH_MAGIC;
            queue_record(K_LENGTH, word, 4'd0, ERR_NONE, 1'b1);
          end
        end
        default: begin
          if (word != magic_word) begin
            halt(word, ERR_MAGIC);
          end else begin
            phase = PH_ATOMS;
          end
        end
      endcase
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
      $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
      mismatches++;
    endfunction

    function void match_record(logic [3:0] kind, logic [31:0] value, logic [3:0] idx,
                               logic [1:0] err, logic last_flag);
      result_t want;
      if (due_records.size() == 0) begin
        $display("%0t: unexpected record, expected none actual kind %0d value %h",
                 $time, kind, value);
        mismatches++;
        return;
      end
      want = due_records.pop_front();
      checked++;
      if (kind !== want.kind) report("record_kind", want.kind, kind);
      if (value !== want.value) report("word_value", want.value, value);
      if (idx !== want.idx) report("element_index", want.idx, idx);
      if (err !== want.err) report("error_code", want.err, err);
      if (last_flag !== want.last) report("last", want.last, last_flag);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        byte_valid = 1'b0;
  logic        byte_ready;
  logic [7:0]  data_byte = 8'd0;
  logic        rec_valid;
  logic        rec_ready = 1'b0;
  logic [3:0]  record_kind;
  logic signed [31:0] word_value;
  logic [3:0]  element_index;
  logic [1:0]  error_code;
  logic        last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [31:0] cfg_data = 32'd0;

  record_scoreboard sb;
  logic [7:0]  byte_feed[$];
  logic [31:0] cur_magic = MagicReset;
  logic [7:0]  cur_limit = LimitReset;
  int unsigned bytes_in = 0;
  int unsigned idle_cycles = 0;
  int unsigned frames_built = 0;
  int unsigned settings = 0;
  bit          held_off = 1'b0;
  string       tail_case;

  trajectory_frame_deframer dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    bit moved;
    moved = 1'b0;
    if (byte_valid && byte_ready) begin
      sb.take_byte(data_byte);
      bytes_in++;
      moved = 1'b1;
    end
    if (rec_valid && rec_ready) begin
      sb.match_record(record_kind, word_value, element_index, error_code, last);
      moved = 1'b1;
    end
    if (cfg_valid && cfg_ready) begin
      sb.set_reg(cfg_index, cfg_data);
      moved = 1'b1;
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
  end

  initial begin : receiver
    rx_mode_t    mode;
    int unsigned span;
    int unsigned tick;
    mode = RX_OPEN;
    span = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      // hold off once while bytes keep coming
      if (!held_off && bytes_in >= 300) begin
        rec_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held_off = 1'b1;
      end
      if (span == 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        span = $urandom_range(20, 200);
      end
      span--;
      tick++;
      case (mode)
        RX_OPEN:  rec_ready <= 1'b1;
        RX_LIGHT: rec_ready <= ($urandom_range(0, 3) != 0);
        RX_HEAVY: rec_ready <= ($urandom_range(0, 3) == 0);
        default:  rec_ready <= ((tick % 5) < 2);
      endcase
    end
  end

  initial begin : watchdog
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  function automatic logic [31:0] filler(fill_t fill);
    case (fill)
      FILL_ZERO: return 32'd0;
      FILL_ONES: return 32'hFFFF_FFFF;
      default:   return $urandom();
    endcase
  endfunction

  task automatic put_word(input logic [31:0] w);
    for (int k = 3; k >= 0; k--) byte_feed.push_back(w[8*k +: 8]);
  endtask

  task automatic add_frame(input logic [31:0] magic, input logic [31:0] atoms,
                           input logic [31:0] count, input logic [31:0] plen,
                           input fill_t fill);
    logic [1:0]  pad;
    logic [31:0] fw;
    pad = 2'd0 - plen[1:0];
    put_word(magic);
    put_word(atoms);
    repeat (11) put_word(filler(fill));
    put_word(count);
    repeat (8) put_word(filler(fill));
    put_word(plen);
    repeat (plen) begin
      fw = filler(fill);
      byte_feed.push_back(fw[7:0]);
    end
    repeat (pad) byte_feed.push_back(8'($urandom_range(0, 255)));
    frames_built++;
  endtask

  task automatic add_random_frame();
    logic [31:0] atoms;
    logic [31:0] count;
    logic [31:0] plen;
    if ($urandom_range(0, 1) == 0) begin
      atoms = {24'd0, cur_limit} + 32'd1 + $urandom_range(0, 40);
    end else begin
      atoms = $urandom() >> 1;
      if (atoms <= 32'd255) atoms = atoms + 32'd256;
    end
    case ($urandom_range(0, 3))
      0:       count = atoms;
      1:       count = $urandom_range(atoms, 0);
      2:       count = 32'h8000_0000 | $urandom();
      default: count = 32'd0;
    endcase
    plen = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(0, 12);
    add_frame(cur_magic, atoms, count, plen,
              ($urandom_range(0, 15) == 0) ? FILL_ZERO : FILL_RANDOM);
  endtask

  task automatic push_stream();
    int unsigned burst;
    int unsigned gap;
    bit steady;
    steady = ($urandom_range(0, 3) == 0);
    burst = $urandom_range(1, 24);
    while (byte_feed.size() != 0) begin
      if (!steady && burst == 0) begin
        byte_valid <= 1'b0;
        gap = $urandom_range(1, 6);
        repeat (gap) @(posedge clk);
        burst = $urandom_range(1, 24);
      end
      byte_valid <= 1'b1;
      data_byte <= byte_feed.pop_front();
      do @(posedge clk); while (!byte_ready);
      if (burst != 0) burst--;
    end
    byte_valid <= 1'b0;
  endtask

  task automatic settle();
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input logic [31:0] magic, input logic [31:0] limit_word);
    logic [1:0]  addr [4];
    logic [31:0] data [4];
    addr = '{REG_MAGIC, REG_SPARE, REG_LIMIT, REG_TOP};
    data = '{magic, $urandom(), limit_word, $urandom()};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= addr[i];
      cfg_data <= data[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    cur_magic = magic;
    cur_limit = limit_word[7:0];
    settings++;
  endtask

  task automatic run_phase();
    while (byte_feed.size() < PHASE_BYTES) add_random_frame();
    push_stream();
    settle();
  endtask

  initial begin
    logic [31:0] atoms;
    logic [31:0] count;
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // boundary frames at reset values
    atoms = {24'd0, cur_limit} + 32'd1;
    add_frame(cur_magic, atoms, atoms, 32'd0, FILL_ZERO);
    add_frame(cur_magic, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1, FILL_ONES);
    add_frame(cur_magic, 32'h0000_0100, 32'h8000_0000, 32'd6, FILL_RANDOM);
    push_stream();
    settle();

    write_config(32'd0, 32'hFFFF_FF00);
    run_phase();
    write_config(32'hFFFF_FFFF, 32'h0000_00FF);
    run_phase();
    write_config($urandom(), $urandom());
    run_phase();
    write_config(MagicReset, {24'd0, LimitReset});
    run_phase();

    // close with one broken frame, then noise that must be dropped
    case ($urandom_range(0, 2))
      0: begin
        tail_case = "bad magic word";
        add_frame(cur_magic ^ (32'd1 << $urandom_range(0, 31)),
                  {24'd0, cur_limit} + 32'd1, 32'd0, 32'd4, FILL_RANDOM);
      end
      1: begin
        tail_case = "count above atom total";
        atoms = $urandom();
        if (atoms == 32'h7FFF_FFFF) atoms = 32'd0;
        add_frame(cur_magic, atoms, atoms + 32'd1, 32'd4, FILL_RANDOM);
      end
      default: begin
        tail_case = "atom total at or below limit";
        if ($urandom_range(0, 1) == 0) atoms = $urandom_range(0, cur_limit);
        else atoms = 32'h8000_0000 | $urandom();
        count = ($urandom_range(0, 1) == 0) ? atoms : 32'h8000_0000;
        add_frame(cur_magic, atoms, count, 32'd4, FILL_RANDOM);
      end
    endcase
    repeat (40) byte_feed.push_back(8'($urandom_range(0, 255)));
    push_stream();
    settle();

    $display("Run: %0d bytes fed, %0d records checked, %0d frames, %0d register settings",
             bytes_in, sb.checked, frames_built, settings);
    $display("Stream closed on a %s, followed by dropped noise", tail_case);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
